/* src/nlas_pkg.sv */
package nlas_pkg;

	localparam int SERIES_TERMS = 15;
	localparam int FRAC_BITS    = 30;
	localparam int QUO_BITS     = 30;
	localparam int ONE_Q16      = 65536;

	// Divider word: quotient bits found so far, remainder and divisor
	typedef struct packed {
		logic        vld;
		logic        neg;
		logic [33:0] rem;
		logic [32:0] den;
		logic [30:0] quo;
	} nlas_div_t;

	// Series word
	typedef struct packed {
		logic        vld;
		logic        neg;
		logic [30:0] xmag;
		logic [31:0] xx;
		logic [31:0] y;
	} nlas_ser_t;

	// Odd reciprocal in Q2.30, rounded to nearest
	function automatic logic [31:0] recip_q30(input logic [5:0] k);
		logic [31:0] d;
		logic [63:0] r;
		d = 32'(2 * int'(k) + 1);
		r = ((64'd1 << FRAC_BITS) + 64'(d >> 1)) / 64'(d);
		return r[31:0];
	endfunction

endpackage

/* src/natural_log_atanh_series_core.sv */
// Natural logarithm core: value (unsigned Q16.16) in, log_value (signed Q4.27)
// out. Fully pipelined: a word may start every cycle (busy is always low) and
// its result appears on log_value with done high once it has passed the
// divider load and its 30 quotient stages, the two-stage square, the two-stage
// Horner steps and the two-stage final product. done cannot be held off.
module natural_log_atanh_series_core import nlas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        value,
	output logic               done,
	output logic signed [31:0] log_value
);

	nlas_div_t   dv;
	nlas_ser_t   sq_s1;
	nlas_ser_t   sq_s2;
	logic [61:0] sqp_s1;
	nlas_ser_t   hs [0:SERIES_TERMS];
	nlas_ser_t   fin_s1;
	logic [63:0] prod_s1;

	assign busy = 1'b0;

	nlas_div u_div (.clk(clk), .arst_n(arst_n), .start(start), .value(value), .res(dv));

	// Square x, round and seed the series
	always_ff @(posedge clk or negedge arst_n) begin
		logic [61:0] r;
		if (!arst_n) begin
			sq_s1  <= '0;
			sqp_s1 <= '0;
			sq_s2  <= '0;
		end else begin
			sq_s1.vld  <= dv.vld;
			sq_s1.neg  <= dv.neg;
			sq_s1.xmag <= dv.quo;
			sq_s1.xx   <= '0;
			sq_s1.y    <= '0;
			sqp_s1     <= 62'(dv.quo) * 62'(dv.quo);

			r = (sqp_s1 + (62'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			sq_s2.vld  <= sq_s1.vld;
			sq_s2.neg  <= sq_s1.neg;
			sq_s2.xmag <= sq_s1.xmag;
			sq_s2.xx   <= r[31:0];
			sq_s2.y    <= recip_q30(6'(SERIES_TERMS));
		end
	end

	assign hs[0] = sq_s2;

	// Horner chain, innermost term first
	for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_h
		nlas_horner u_h (
			.clk(clk), .arst_n(arst_n), .recip(recip_q30(6'(SERIES_TERMS - 1 - i))),
			.din(hs[i]), .dout(hs[i+1])
		);
	end

	// Final product 2*x*y, then round, saturate, apply sign
	always_ff @(posedge clk or negedge arst_n) begin
		logic [63:0] m;
		if (!arst_n) begin
			fin_s1    <= '0;
			prod_s1   <= '0;
			done      <= 1'b0;
			log_value <= '0;
		end else begin
			fin_s1.vld  <= hs[SERIES_TERMS].vld;
			fin_s1.neg  <= hs[SERIES_TERMS].neg;
			fin_s1.xmag <= '0;
			fin_s1.xx   <= '0;
			fin_s1.y    <= '0;
			prod_s1     <= 64'(hs[SERIES_TERMS].xmag) * 64'(hs[SERIES_TERMS].y);

			done <= fin_s1.vld;
			m = (prod_s1 + (64'd1 << 31)) >> 32;
			if (fin_s1.neg) begin
				if (m > 64'h8000_0000) m = 64'h8000_0000;
				log_value <= 32'(64'd0 - m);
			end else begin
				if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
				log_value <= 32'(m);
			end
		end
	end

endmodule

/* src/nlas_div.sv */
// Restoring divider, one quotient bit per stage, then rounding
module nlas_div import nlas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output nlas_div_t   res
);

	nlas_div_t stg_s [0:QUO_BITS];

	// Load numerator and divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s[0] <= '0;
		end else begin
			stg_s[0].vld <= start;
			stg_s[0].neg <= value < 32'(ONE_Q16);
			stg_s[0].rem <= (value < 32'(ONE_Q16)) ? 34'(32'(ONE_Q16) - value)
			                                       : 34'(value - 32'(ONE_Q16));
			stg_s[0].den <= 33'(value) + 33'(ONE_Q16);
			stg_s[0].quo <= '0;
		end
	end

	// One quotient bit per stage
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_bit
		logic [34:0] sh;
		logic [34:0] df;
		assign sh = {stg_s[i].rem, 1'b0};
		assign df = sh - 35'(stg_s[i].den);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_s[i+1] <= '0;
			end else begin
				stg_s[i+1].vld <= stg_s[i].vld;
				stg_s[i+1].neg <= stg_s[i].neg;
				stg_s[i+1].den <= stg_s[i].den;
				if (!df[34]) begin
					stg_s[i+1].rem <= df[33:0];
					stg_s[i+1].quo <= {stg_s[i].quo[29:0], 1'b1};
				end else begin
					stg_s[i+1].rem <= sh[33:0];
					stg_s[i+1].quo <= {stg_s[i].quo[29:0], 1'b0};
				end
			end
		end
	end

	// Round half up: q*2+1 quotient bit is rem*2 >= den
	always_comb begin
		res = stg_s[QUO_BITS];
		if ({stg_s[QUO_BITS].rem, 1'b0} >= 35'(stg_s[QUO_BITS].den))
			res.quo = stg_s[QUO_BITS].quo + 31'd1;
	end

endmodule

/* src/nlas_horner.sv */
// One Horner step: y = recip + round(xx*y / 2^30); multiply, then add
module nlas_horner import nlas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] recip,
	input  nlas_ser_t   din,
	output nlas_ser_t   dout
);

	nlas_ser_t   a_s1;
	logic [63:0] p_s1;

	// Multiply, then round and add reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		logic [63:0] r;
		if (!arst_n) begin
			a_s1 <= '0;
			p_s1 <= '0;
			dout <= '0;
		end else begin
			a_s1.vld  <= din.vld;
			a_s1.neg  <= din.neg;
			a_s1.xmag <= din.xmag;
			a_s1.xx   <= din.xx;
			a_s1.y    <= din.y;
			p_s1      <= 64'(din.xx) * 64'(din.y);

			r = (p_s1 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			dout.vld  <= a_s1.vld;
			dout.neg  <= a_s1.neg;
			dout.xmag <= a_s1.xmag;
			dout.xx   <= a_s1.xx;
			dout.y    <= recip + r[31:0];
		end
	end

endmodule

/* tb/natural_log_atanh_series_core_test.sv */
`timescale 1ns / 100ps

module natural_log_atanh_series_core_test;
	import nlas_pkg::*;

	localparam int LATENCY = 2 * SERIES_TERMS + 36;
	localparam longint CYCLE_LIMIT = 400000;

	// Expected log values in acceptance order; predictor lives here too
	class log_scoreboard;
		logic signed [31:0] pending_logs[$];
		int mismatches;

		function automatic logic [63:0] odd_recip(input int odd);
			return ((64'd1 << 30) + 64'(odd / 2)) / 64'(odd);
		endfunction

		function automatic logic signed [31:0] predict_log(input logic [31:0] arg);
			logic neg;
			logic [63:0] num, den, xmag, xx, y, mag;
			int nk;
			neg = arg < 32'd65536;
			num = neg ? 64'(32'd65536 - arg) : 64'(arg) - 64'd65536;
			den = 64'(arg) + 64'd65536;
			xmag = ((num << 30) + den / 2) / den;
			xx = (xmag * xmag + (64'd1 << 29)) >> 30;
			nk = 2 * SERIES_TERMS + 1;
			y = odd_recip(nk);
			for (int k = SERIES_TERMS; k > 0; k--) begin
				nk -= 2;
				y = odd_recip(nk) + ((xx * y + (64'd1 << 29)) >> 30);
			end
			mag = (xmag * y + (64'd1 << 31)) >> 32;
			if (neg) begin
				if (mag > 64'h8000_0000) mag = 64'h8000_0000;
				return 32'(64'd0 - mag);
			end
			if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
			return mag[31:0];
		endfunction

		function void note_word(input logic [31:0] arg);
			pending_logs.push_back(predict_log(arg));
		endfunction

		function void check_word(input logic signed [31:0] got);
			logic signed [31:0] want;
			if (pending_logs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: log_value=%0d", got);
				return;
			end
			want = pending_logs.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("log_value mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic [31:0] value;
	logic signed [31:0] log_value;
	log_scoreboard board;
	int idle_pct;
	longint cycles;

	natural_log_atanh_series_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.value(value), .done(done), .log_value(log_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Note accepted words, check results at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) board.note_word(value);
			if (done) board.check_word(log_value);
		end
	end

	// Guard against a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Present one word, with random idle cycles before it
	task automatic send_word(input logic [31:0] arg);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		value <= arg;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Random argument: some anywhere, some from 0 to 2.0, some below one, some up to 256.0
	function automatic logic [31:0] random_arg();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'd65536 + 32'($urandom_range(131072)) - 32'd65536;
			2: return 32'($urandom_range(65535));
			default: return $urandom_range(32'h0100_0000);
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$];
		board = new();
		cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero, one, extremes and a walk of single bits
		directed = '{32'd0, 32'd1, 32'd65535, 32'd65536, 32'd65537, 32'd131072,
			32'hFFFF_FFFF, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd32768, 32'd178145};
		foreach (directed[i]) send_word(directed[i]);
		for (int b = 0; b < 32; b += 4) send_word(32'd1 << b);

		// Random phases: no idling, mostly idle, a little idle, no idling again
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 83 : (ph == 2) ? 11 : 0;
			for (int i = 0; i < 350; i++) send_word(random_arg());
		end
		start <= 1'b0;

		// Drain the pipeline
		while (board.pending_logs.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (board.mismatches == 0 && board.pending_logs.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
